### hdl/metadata_piece_request_scheduler_core_macros.svh
// Assertion macros shared by the metadata piece request scheduler files.
`ifndef METADATA_PIECE_REQUEST_SCHEDULER_CORE_MACROS_SVH
`define METADATA_PIECE_REQUEST_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MPRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MPRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mprs_pkg.sv
// Shared constants, codes and types of the metadata piece request scheduler.
`timescale 1ns / 1ps

package mprs_pkg;

    // Fixed field widths.
    localparam int IDX_W      = 6;
    localparam int LEN_W      = 15;
    localparam int TIME_W     = 32;
    localparam int META_W     = 21;
    localparam int INTERVAL_W = 8;
    localparam int STATUS_W   = 3;
    localparam int CNT_OUT_W  = 7;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    // Parameter defaults.
    localparam int MAX_PIECES_DEF  = 64;
    localparam int PIECE_BYTES_DEF = 16384;

    localparam logic [INTERVAL_W-1:0] REPEAT_RESET = INTERVAL_W'(3);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_METADATA_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd1;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_START   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POLL    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PIECE   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_VERDICT = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_DUE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INACTIVE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_NEEDED = 3'd4;

    // Commands broadcast to every list cell.
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op CELL_HOLD = 2'd0;
    localparam t_cell_op CELL_FILL = 2'd1;
    localparam t_cell_op CELL_MARK = 2'd2;
    localparam t_cell_op CELL_WALK = 2'd3;

    // Status reported by the cell chain to the controller.
    typedef struct packed {
        logic found;     // some live cell matches the lookup key
        logic done;      // the hole sits in the last live cell
        logic any_hole;  // a hole is present somewhere in the chain
    } t_chain_stat;

endpackage

### hdl/mprs_cell.sv
// One list cell: holds a piece number and its last request time.
`timescale 1ns / 1ps

module mprs_cell #(
    parameter int IDX     = 0,
    parameter int PIECE_W = 6,
    parameter int KEY_W   = 6,
    parameter int CNT_W   = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mprs_pkg::t_cell_op         i_op,
    input  logic                       i_head_mark,
    input  logic [KEY_W-1:0]           i_key,
    input  logic [CNT_W-1:0]           i_count,
    input  logic                       i_ins_en,
    input  logic [PIECE_W-1:0]         i_ins_piece,
    input  logic [mprs_pkg::TIME_W-1:0] i_ins_time,
    input  logic                       i_prev_fwd,
    input  logic [PIECE_W-1:0]         i_next_piece,
    input  logic [mprs_pkg::TIME_W-1:0] i_next_time,
    output logic [PIECE_W-1:0]         o_piece,
    output logic [mprs_pkg::TIME_W-1:0] o_time,
    output logic                       o_fwd,
    output logic                       o_match,
    output logic                       o_done,
    output logic                       o_hole
);

    localparam logic [CNT_W-1:0] POS_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] POS_P1 = CNT_W'(IDX + 1);

    logic                        r_hole, n_hole;
    logic [PIECE_W-1:0]          r_piece, n_piece;
    logic [mprs_pkg::TIME_W-1:0] r_time, n_time;
    logic                        w_last;
    logic                        w_match;

    // The last live cell is the one at position count - 1.
    assign w_last  = (i_count == POS_P1);
    assign w_match = (KEY_W'(r_piece) == i_key) && (POS_C < i_count);

    always_comb begin
        n_hole  = r_hole;
        n_piece = r_piece;
        n_time  = r_time;
        case (i_op)
            mprs_pkg::CELL_FILL: begin
                n_piece = PIECE_W'(IDX);
                n_time  = '0;
                n_hole  = 1'b0;
            end
            mprs_pkg::CELL_MARK: begin
                // A head mark opens the hole at position zero; otherwise the lookup does.
                n_hole = i_head_mark ? (IDX == 0) : w_match;
            end
            mprs_pkg::CELL_WALK: begin
                n_hole = i_prev_fwd;
                if (r_hole) begin
                    if (w_last) begin
                        if (i_ins_en) begin
                            n_piece = i_ins_piece;
                            n_time  = i_ins_time;
                        end
                    end else begin
                        n_piece = i_next_piece;
                        n_time  = i_next_time;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hole <= 1'b0;
        end else begin
            r_hole <= n_hole;
        end
    end

    always_ff @(posedge i_clk) begin
        r_piece <= n_piece;
        r_time  <= n_time;
    end

    assign o_piece = r_piece;
    assign o_time  = r_time;
    assign o_fwd   = r_hole && !w_last;
    assign o_match = w_match;
    assign o_done  = r_hole && w_last;
    assign o_hole  = r_hole;

endmodule

### hdl/mprs_chain.sv
// Row of list cells with neighbor links and status reduction.
`timescale 1ns / 1ps
`include "metadata_piece_request_scheduler_core_macros.svh"

module mprs_chain #(
    parameter int MAX_PIECES = mprs_pkg::MAX_PIECES_DEF,
    parameter int PIECE_W    = 6,
    parameter int KEY_W      = 6,
    parameter int CNT_W      = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mprs_pkg::t_cell_op          i_op,
    input  logic                        i_head_mark,
    input  logic [KEY_W-1:0]            i_key,
    input  logic [CNT_W-1:0]            i_count,
    input  logic                        i_ins_en,
    input  logic [PIECE_W-1:0]          i_ins_piece,
    input  logic [mprs_pkg::TIME_W-1:0] i_ins_time,
    output logic [PIECE_W-1:0]          o_head_piece,
    output logic [mprs_pkg::TIME_W-1:0] o_head_time,
    output mprs_pkg::t_chain_stat       o_stat
);

    logic [PIECE_W-1:0]          w_piece [MAX_PIECES];
    logic [mprs_pkg::TIME_W-1:0] w_time  [MAX_PIECES];
    logic [MAX_PIECES-1:0]       w_fwd;
    logic [MAX_PIECES-1:0]       w_match;
    logic [MAX_PIECES-1:0]       w_done;
    logic [MAX_PIECES-1:0]       w_hole;

    for (genvar g = 0; g < MAX_PIECES; g++) begin : g_cell
        logic                        w_prev_fwd;
        logic [PIECE_W-1:0]          w_next_piece;
        logic [mprs_pkg::TIME_W-1:0] w_next_time;

        if (g == 0) begin : g_first
            assign w_prev_fwd = 1'b0;
        end else begin : g_mid
            assign w_prev_fwd = w_fwd[g-1];
        end

        if (g == MAX_PIECES - 1) begin : g_end
            assign w_next_piece = '0;
            assign w_next_time  = '0;
        end else begin : g_link
            assign w_next_piece = w_piece[g+1];
            assign w_next_time  = w_time[g+1];
        end

        mprs_cell #(
            .IDX     (g),
            .PIECE_W (PIECE_W),
            .KEY_W   (KEY_W),
            .CNT_W   (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (i_op),
            .i_head_mark  (i_head_mark),
            .i_key        (i_key),
            .i_count      (i_count),
            .i_ins_en     (i_ins_en),
            .i_ins_piece  (i_ins_piece),
            .i_ins_time   (i_ins_time),
            .i_prev_fwd   (w_prev_fwd),
            .i_next_piece (w_next_piece),
            .i_next_time  (w_next_time),
            .o_piece      (w_piece[g]),
            .o_time       (w_time[g]),
            .o_fwd        (w_fwd[g]),
            .o_match      (w_match[g]),
            .o_done       (w_done[g]),
            .o_hole       (w_hole[g])
        );
    end

    assign o_head_piece    = w_piece[0];
    assign o_head_time     = w_time[0];
    assign o_stat.found    = |w_match;
    assign o_stat.done     = |w_done;
    assign o_stat.any_hole = |w_hole;

    // The list holds each piece once, so a lookup and a walk involve one hole at most.
    `MPRS_ASSERT_NOW(a_one_hole, i_clk, i_rst_n, 1'b1, $onehot0(w_hole), "more than one hole")
    `MPRS_ASSERT_NOW(a_one_match, i_clk, i_rst_n, i_op == mprs_pkg::CELL_MARK && !i_head_mark,
        $onehot0(w_match), "lookup matched more than one live cell")
    `MPRS_ASSERT_NEXT(a_walk_moves, i_clk, i_rst_n,
        i_op == mprs_pkg::CELL_WALK && (|w_fwd), |w_hole, "walking hole was lost")

endmodule

### hdl/metadata_piece_request_scheduler_core.sv
// Top level of the metadata piece request scheduler: controller and cell chain.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    i_req_type .. i_verify_ok (five fields)
//   out      output     o_out_valid / i_out_ready  o_status .. o_finished (six fields)
//   cfg      input      i_cfg_we, no wait          i_cfg_index, i_cfg_data
//
// One item at a time: a transfer is taken in the idle state, evaluated next cycle, then registered.
// Rejected items and verdicts go straight from evaluation to the finish state; a start first counts
// the pieces, one piece size added per cycle. A granted poll and a received piece first walk
// the hole one cell per cycle from the head or the matching entry to the tail.
// Synchronous reset clears the control state only; every live cell is filled before it is read.
// A stalled result waits in the output register; only the next item's completion waits on it.
`timescale 1ns / 1ps
`include "metadata_piece_request_scheduler_core_macros.svh"

module metadata_piece_request_scheduler_core #(
    parameter int MAX_PIECES  = mprs_pkg::MAX_PIECES_DEF,
    parameter int PIECE_BYTES = mprs_pkg::PIECE_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration port.
    input  logic                             i_cfg_we,
    input  logic [mprs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mprs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input channel.
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [mprs_pkg::REQ_W-1:0]       i_req_type,
    input  logic [mprs_pkg::TIME_W-1:0]      i_now_secs,
    input  logic [mprs_pkg::IDX_W-1:0]       i_piece_index,
    input  logic [mprs_pkg::LEN_W-1:0]       i_piece_len,
    input  logic                             i_verify_ok,
    // Output channel.
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [mprs_pkg::STATUS_W-1:0]    o_status,
    output logic [mprs_pkg::IDX_W-1:0]       o_request_piece,
    output logic                             o_all_received,
    output logic [mprs_pkg::CNT_OUT_W-1:0]   o_pieces_remaining,
    output logic [mprs_pkg::CNT_OUT_W-1:0]   o_pieces_total,
    output logic                             o_finished
);

    localparam int CNT_W   = $clog2(MAX_PIECES + 1);
    localparam int PIECE_W = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
    localparam int KEY_W   = (PIECE_W > mprs_pkg::IDX_W) ? PIECE_W : mprs_pkg::IDX_W;
    // The byte accumulator stops at most one piece past a 21-bit size.
    localparam int ACC_W   = mprs_pkg::META_W + 1;
    localparam int PB_W    = $clog2(PIECE_BYTES + 1);
    localparam int PRD_B   = mprs_pkg::IDX_W + PB_W;
    localparam int PROD_W  = ((PRD_B > mprs_pkg::LEN_W) ? PRD_B : mprs_pkg::LEN_W) + 1;
    localparam int CMP_W   = (PROD_W > mprs_pkg::META_W) ? PROD_W : mprs_pkg::META_W;
    localparam int DUE_W   = mprs_pkg::TIME_W + 1;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIECES);

    // Controller states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_COUNT  = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    // Configuration registers.
    logic [mprs_pkg::META_W-1:0]     r_bytes, n_bytes;
    logic [mprs_pkg::INTERVAL_W-1:0] r_interval, n_interval;

    // Scheduler state.
    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_total, n_total;
    logic             r_active, n_active;
    logic             r_complete, n_complete;

    // Item being worked on.
    logic [mprs_pkg::REQ_W-1:0]  r_kind, n_kind;
    logic [mprs_pkg::TIME_W-1:0] r_now, n_now;
    logic [mprs_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [mprs_pkg::LEN_W-1:0]  r_len, n_len;
    logic                        r_ok, n_ok;

    // Piece counting for a start.
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_n, n_n;

    // Pending result.
    logic [mprs_pkg::STATUS_W-1:0] r_status, n_status;
    logic [PIECE_W-1:0]            r_grant, n_grant;
    logic                          r_all, n_all;

    // Output register.
    logic                           r_out_valid, n_out_valid;
    logic [mprs_pkg::STATUS_W-1:0]  r_out_status, n_out_status;
    logic [mprs_pkg::IDX_W-1:0]     r_out_piece, n_out_piece;
    logic                           r_out_all, n_out_all;
    logic [mprs_pkg::CNT_OUT_W-1:0] r_out_remaining, n_out_remaining;
    logic [mprs_pkg::CNT_OUT_W-1:0] r_out_total, n_out_total;
    logic                           r_out_finished, n_out_finished;

    // Chain interface.
    mprs_pkg::t_cell_op          w_op;
    logic                        w_head_mark;
    logic [PIECE_W-1:0]          w_head_piece;
    logic [mprs_pkg::TIME_W-1:0] w_head_time;
    mprs_pkg::t_chain_stat       w_stat;

    logic             w_in_xfer;
    logic             w_too_long;
    logic             w_due;
    logic [CMP_W-1:0] w_end_byte;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;

    // End of the received piece in bytes, checked against the metadata size.
    assign w_end_byte = CMP_W'(PROD_W'(r_idx) * PROD_W'(PIECE_BYTES) + PROD_W'(r_len));
    assign w_too_long = w_end_byte > CMP_W'(r_bytes);

    // The head is due once its request time plus the interval lies before now, without wrap.
    assign w_due = (DUE_W'(w_head_time) + DUE_W'(r_interval)) < DUE_W'(r_now);

    always_comb begin
        n_bytes         = r_bytes;
        n_interval      = r_interval;
        n_state         = r_state;
        n_count         = r_count;
        n_total         = r_total;
        n_active        = r_active;
        n_complete      = r_complete;
        n_kind          = r_kind;
        n_now           = r_now;
        n_idx           = r_idx;
        n_len           = r_len;
        n_ok            = r_ok;
        n_acc           = r_acc;
        n_n             = r_n;
        n_status        = r_status;
        n_grant         = r_grant;
        n_all           = r_all;
        n_out_valid     = r_out_valid;
        n_out_status    = r_out_status;
        n_out_piece     = r_out_piece;
        n_out_all       = r_out_all;
        n_out_remaining = r_out_remaining;
        n_out_total     = r_out_total;
        n_out_finished  = r_out_finished;
        w_op            = mprs_pkg::CELL_HOLD;
        w_head_mark     = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_index)
                mprs_pkg::CFG_METADATA_BYTES: begin
                    n_bytes = i_cfg_data[mprs_pkg::META_W-1:0];
                end
                mprs_pkg::CFG_REPEAT_INTERVAL: begin
                    n_interval = i_cfg_data[mprs_pkg::INTERVAL_W-1:0];
                end
                default: begin
                end
            endcase
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_kind  = i_req_type;
                    n_now   = i_now_secs;
                    n_idx   = i_piece_index;
                    n_len   = i_piece_len;
                    n_ok    = i_verify_ok;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_grant = '0;
                n_all   = 1'b0;
                n_state = S_FINISH;
                case (r_kind)
                    mprs_pkg::REQ_START: begin
                        if (r_active || r_complete) begin
                            n_status = mprs_pkg::ST_NOT_NEEDED;
                        end else begin
                            n_acc   = '0;
                            n_n     = '0;
                            n_state = S_COUNT;
                        end
                    end
                    mprs_pkg::REQ_POLL: begin
                        if (!r_active) begin
                            n_status = mprs_pkg::ST_INACTIVE;
                        end else if (r_count == '0 || !w_due) begin
                            n_status = mprs_pkg::ST_NOT_DUE;
                        end else begin
                            // Open a hole at the head; the head entry goes to the tail.
                            w_op        = mprs_pkg::CELL_MARK;
                            w_head_mark = 1'b1;
                            n_grant     = w_head_piece;
                            n_status    = mprs_pkg::ST_OK;
                            n_state     = S_WALK;
                        end
                    end
                    mprs_pkg::REQ_PIECE: begin
                        if (!r_active) begin
                            n_status = mprs_pkg::ST_INACTIVE;
                        end else if (w_too_long) begin
                            n_status = mprs_pkg::ST_TOO_LONG;
                        end else begin
                            // Open a hole at the matching entry, if there is one.
                            w_op = mprs_pkg::CELL_MARK;
                            if (w_stat.found) begin
                                n_status = mprs_pkg::ST_OK;
                                n_state  = S_WALK;
                            end else begin
                                n_status = mprs_pkg::ST_NOT_NEEDED;
                            end
                        end
                    end
                    default: begin
                        if (!r_active) begin
                            n_status = mprs_pkg::ST_INACTIVE;
                        end else if (r_count != '0 || r_total == '0) begin
                            n_status = mprs_pkg::ST_NOT_NEEDED;
                        end else begin
                            if (r_ok) begin
                                n_complete = 1'b1;
                                n_active   = 1'b0;
                            end else begin
                                w_op    = mprs_pkg::CELL_FILL;
                                n_count = r_total;
                            end
                            n_status = mprs_pkg::ST_OK;
                        end
                    end
                endcase
            end
            S_COUNT: begin
                // One piece size per cycle until the size is covered or the list is full.
                if (r_n != MAX_CNT && ACC_W'(r_bytes) > r_acc) begin
                    n_acc = r_acc + ACC_W'(PIECE_BYTES);
                    n_n   = r_n + CNT_W'(1);
                end else begin
                    w_op     = mprs_pkg::CELL_FILL;
                    n_total  = r_n;
                    n_count  = r_n;
                    n_active = 1'b1;
                    n_status = mprs_pkg::ST_OK;
                    n_state  = S_FINISH;
                end
            end
            S_WALK: begin
                w_op = mprs_pkg::CELL_WALK;
                if (w_stat.done) begin
                    // A poll re-inserts at the tail and keeps the count; a piece shrinks it.
                    if (r_kind != mprs_pkg::REQ_POLL) begin
                        n_count = r_count - CNT_W'(1);
                        n_all   = (r_count == CNT_W'(1));
                    end
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid     = 1'b1;
                    n_out_status    = r_status;
                    n_out_piece     = mprs_pkg::IDX_W'(r_grant);
                    n_out_all       = r_all;
                    n_out_remaining = mprs_pkg::CNT_OUT_W'(r_count);
                    n_out_total     = mprs_pkg::CNT_OUT_W'(r_total);
                    n_out_finished  = r_complete;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes     <= '0;
            r_interval  <= mprs_pkg::REPEAT_RESET;
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_active    <= 1'b0;
            r_complete  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_bytes     <= n_bytes;
            r_interval  <= n_interval;
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_active    <= n_active;
            r_complete  <= n_complete;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind          <= n_kind;
        r_now           <= n_now;
        r_idx           <= n_idx;
        r_len           <= n_len;
        r_ok            <= n_ok;
        r_acc           <= n_acc;
        r_n             <= n_n;
        r_status        <= n_status;
        r_grant         <= n_grant;
        r_all           <= n_all;
        r_out_status    <= n_out_status;
        r_out_piece     <= n_out_piece;
        r_out_all       <= n_out_all;
        r_out_remaining <= n_out_remaining;
        r_out_total     <= n_out_total;
        r_out_finished  <= n_out_finished;
    end

    mprs_chain #(
        .MAX_PIECES (MAX_PIECES),
        .PIECE_W    (PIECE_W),
        .KEY_W      (KEY_W),
        .CNT_W      (CNT_W)
    ) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_op),
        .i_head_mark  (w_head_mark),
        .i_key        (KEY_W'(r_idx)),
        .i_count      (r_count),
        .i_ins_en     (r_kind == mprs_pkg::REQ_POLL),
        .i_ins_piece  (r_grant),
        .i_ins_time   (r_now),
        .o_head_piece (w_head_piece),
        .o_head_time  (w_head_time),
        .o_stat       (w_stat)
    );

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_request_piece    = r_out_piece;
    assign o_all_received     = r_out_all;
    assign o_pieces_remaining = r_out_remaining;
    assign o_pieces_total     = r_out_total;
    assign o_finished         = r_out_finished;

    // A walk always has its hole somewhere in the chain.
    `MPRS_ASSERT_NOW(a_walk_hole, i_clk, i_rst_n, r_state == S_WALK, w_stat.any_hole,
        "walk state without a hole")
    // No more pieces are needed than the metadata has.
    `MPRS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= r_total && r_total <= MAX_CNT, "piece count out of range")
    // A finished block is never active.
    `MPRS_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, r_complete, !r_active,
        "finished and active at once")

endmodule

### test/metadata_piece_request_scheduler_core_test.sv
// Self-checking testbench for the metadata piece request scheduler core.
`timescale 1ns / 1ps

module metadata_piece_request_scheduler_core_test;

    localparam int PIECE_BYTES     = mprs_pkg::PIECE_BYTES_DEF;
    localparam int LIST_DEPTH      = mprs_pkg::MAX_PIECES_DEF;
    localparam int LEN_MAX         = (1 << mprs_pkg::LEN_W) - 1;
    localparam int META_MAX        = (1 << mprs_pkg::META_W) - 1;
    localparam int RANDOM_ITEMS    = 480;
    localparam int TAIL_CYCLES     = 80;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DIR_ROWS        = 21;

    // One result of the block, at the widths of its output ports.
    typedef struct packed {
        logic [mprs_pkg::STATUS_W-1:0]  status;
        logic [mprs_pkg::IDX_W-1:0]     grant;
        logic                           all_rx;
        logic [mprs_pkg::CNT_OUT_W-1:0] remaining;
        logic [mprs_pkg::CNT_OUT_W-1:0] total;
        logic                           finished;
    } t_sched_result;

    // One directed transfer, optionally preceded by a register update. The expected
    // result is only spelled out where it is obvious; otherwise the predictor supplies it.
    typedef struct packed {
        logic                            set_cfg;
        logic [mprs_pkg::META_W-1:0]     md_bytes;
        logic [mprs_pkg::INTERVAL_W-1:0] interval;
        logic [mprs_pkg::REQ_W-1:0]      kind;
        logic [mprs_pkg::TIME_W-1:0]     now;
        logic [mprs_pkg::IDX_W-1:0]      idx;
        logic [mprs_pkg::LEN_W-1:0]      len;
        logic                            ok;
        logic                            typed;
        t_sched_result                   want;
    } t_dir_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [mprs_pkg::CFG_IDX_W-1:0]   i_cfg_index = mprs_pkg::CFG_METADATA_BYTES;
    logic [mprs_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_ready;
    logic [mprs_pkg::REQ_W-1:0]       i_req_type = mprs_pkg::REQ_POLL;
    logic [mprs_pkg::TIME_W-1:0]      i_now_secs = '0;
    logic [mprs_pkg::IDX_W-1:0]       i_piece_index = '0;
    logic [mprs_pkg::LEN_W-1:0]       i_piece_len = '0;
    logic                             i_verify_ok = 1'b0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic [mprs_pkg::STATUS_W-1:0]    o_status;
    logic [mprs_pkg::IDX_W-1:0]       o_request_piece;
    logic                             o_all_received;
    logic [mprs_pkg::CNT_OUT_W-1:0]   o_pieces_remaining;
    logic [mprs_pkg::CNT_OUT_W-1:0]   o_pieces_total;
    logic                             o_finished;

    // Mirror of the scheduler: the request list with its times, and the control flags.
    logic [mprs_pkg::IDX_W-1:0]      sch_piece [LIST_DEPTH];
    logic [mprs_pkg::TIME_W-1:0]     sch_time  [LIST_DEPTH];
    int                              sch_count = 0;
    int                              sch_total = 0;
    bit                              sch_active = 1'b0;
    bit                              sch_done = 1'b0;
    logic [mprs_pkg::META_W-1:0]     cfg_md = '0;
    logic [mprs_pkg::INTERVAL_W-1:0] cfg_ri = mprs_pkg::REPEAT_RESET;

    t_sched_result awaited_results [$];
    logic [mprs_pkg::TIME_W-1:0] poll_clock = 32'd1000;
    int out_stall_pct = 0;
    int stall_cycles = 0;
    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;
    int grants = 0;
    int lists_emptied = 0;
    int refills = 0;
    int config_writes = 0;

    // Directed rows. The first three run before any start, then the list is built at the
    // saturated piece count, and later rows probe the due test, the length bound and the
    // lookup of pieces that are no longer needed.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_POLL, 32'd0, 6'd0, 15'd0, 1'b0,
          1'b1, '{mprs_pkg::ST_INACTIVE, 6'd0, 1'b0, 7'd0, 7'd0, 1'b0}},
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_PIECE, 32'd0, 6'd0, 15'd0, 1'b0,
          1'b1, '{mprs_pkg::ST_INACTIVE, 6'd0, 1'b0, 7'd0, 7'd0, 1'b0}},
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_VERDICT, 32'd0, 6'd0, 15'd0, 1'b1,
          1'b1, '{mprs_pkg::ST_INACTIVE, 6'd0, 1'b0, 7'd0, 7'd0, 1'b0}},
        '{1'b1, 21'h1FFFFF, 8'd255, mprs_pkg::REQ_START, 32'hFFFFFFFF, 6'd63, 15'h7FFF, 1'b1,
          1'b1, '{mprs_pkg::ST_OK, 6'd0, 1'b0, 7'd64, 7'd64, 1'b0}},
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_START, 32'd0, 6'd0, 15'd0, 1'b0,
          1'b1, '{mprs_pkg::ST_NOT_NEEDED, 6'd0, 1'b0, 7'd64, 7'd64, 1'b0}},
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_VERDICT, 32'd0, 6'd0, 15'd0, 1'b1,
          1'b1, '{mprs_pkg::ST_NOT_NEEDED, 6'd0, 1'b0, 7'd64, 7'd64, 1'b0}},
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_POLL, 32'd0, 6'd0, 15'd0, 1'b0,
          1'b1, '{mprs_pkg::ST_NOT_DUE, 6'd0, 1'b0, 7'd64, 7'd64, 1'b0}},
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_POLL, 32'd255, 6'd0, 15'd0, 1'b0,
          1'b1, '{mprs_pkg::ST_NOT_DUE, 6'd0, 1'b0, 7'd64, 7'd64, 1'b0}},
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_POLL, 32'd256, 6'd0, 15'd0, 1'b0,
          1'b1, '{mprs_pkg::ST_OK, 6'd0, 1'b0, 7'd64, 7'd64, 1'b0}},
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_POLL, 32'hFFFFFFFF, 6'd0, 15'd0, 1'b0,
          1'b1, '{mprs_pkg::ST_OK, 6'd1, 1'b0, 7'd64, 7'd64, 1'b0}},
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_PIECE, 32'd0, 6'd63, 15'h7FFF, 1'b0, 1'b0, '0},
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_PIECE, 32'd0, 6'd63, 15'd0, 1'b0,
          1'b1, '{mprs_pkg::ST_NOT_NEEDED, 6'd0, 1'b0, 7'd63, 7'd64, 1'b0}},
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_PIECE, 32'd0, 6'd0, 15'd16384, 1'b0, 1'b0, '0},
        '{1'b1, 21'd1048576, 8'd0, mprs_pkg::REQ_PIECE, 32'd0, 6'd63, 15'd16385, 1'b0,
          1'b1, '{mprs_pkg::ST_TOO_LONG, 6'd0, 1'b0, 7'd62, 7'd64, 1'b0}},
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_PIECE, 32'd0, 6'd63, 15'd16384, 1'b0,
          1'b1, '{mprs_pkg::ST_NOT_NEEDED, 6'd0, 1'b0, 7'd62, 7'd64, 1'b0}},
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_POLL, 32'd1, 6'd0, 15'd0, 1'b0, 1'b0, '0},
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_POLL, 32'd0, 6'd0, 15'd0, 1'b0, 1'b0, '0},
        '{1'b1, 21'd0, 8'd3, mprs_pkg::REQ_PIECE, 32'd0, 6'd0, 15'd1, 1'b0,
          1'b1, '{mprs_pkg::ST_TOO_LONG, 6'd0, 1'b0, 7'd62, 7'd64, 1'b0}},
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_PIECE, 32'd0, 6'd5, 15'd0, 1'b0,
          1'b1, '{mprs_pkg::ST_TOO_LONG, 6'd0, 1'b0, 7'd62, 7'd64, 1'b0}},
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_PIECE, 32'd0, 6'd0, 15'd0, 1'b0, 1'b0, '0},
        '{1'b0, 21'd0, 8'd0, mprs_pkg::REQ_VERDICT, 32'd0, 6'd0, 15'd0, 1'b0,
          1'b1, '{mprs_pkg::ST_NOT_NEEDED, 6'd0, 1'b0, 7'd62, 7'd64, 1'b0}}
    };

    metadata_piece_request_scheduler_core u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_req_type         (i_req_type),
        .i_now_secs         (i_now_secs),
        .i_piece_index      (i_piece_index),
        .i_piece_len        (i_piece_len),
        .i_verify_ok        (i_verify_ok),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_request_piece    (o_request_piece),
        .o_all_received     (o_all_received),
        .o_pieces_remaining (o_pieces_remaining),
        .o_pieces_total     (o_pieces_total),
        .o_finished         (o_finished)
    );

    always #5 i_clk = ~i_clk;

    // Every piece becomes needed again with a request time of zero.
    function automatic void refill_list();
        int i;
        for (i = 0; i < sch_total; i++) begin
            sch_piece[i] = mprs_pkg::IDX_W'(i);
            sch_time[i]  = '0;
        end
        sch_count = sch_total;
    endfunction

    // Closes the gap left by the entry at list position pos.
    function automatic void drop_entry(input int pos);
        int i;
        for (i = pos; i + 1 < sch_count; i++) begin
            sch_piece[i] = sch_piece[i + 1];
            sch_time[i]  = sch_time[i + 1];
        end
        sch_count--;
    endfunction

    // Applies one accepted transfer to the mirror and returns the result it must produce.
    function automatic t_sched_result advance_scheduler(
        input logic [mprs_pkg::REQ_W-1:0]  kind,
        input logic [mprs_pkg::TIME_W-1:0] now,
        input logic [mprs_pkg::IDX_W-1:0]  idx,
        input logic [mprs_pkg::LEN_W-1:0]  len,
        input logic                        ok
    );
        t_sched_result res;
        logic [mprs_pkg::IDX_W-1:0] head;
        int pos;
        int n;
        res = '0;
        case (kind)
            mprs_pkg::REQ_START: begin
                if (sch_active || sch_done) begin
                    res.status = mprs_pkg::ST_NOT_NEEDED;
                end else begin
                    n = (int'(cfg_md) + PIECE_BYTES - 1) / PIECE_BYTES;
                    sch_total = (n > LIST_DEPTH) ? LIST_DEPTH : n;
                    refill_list();
                    sch_active = 1'b1;
                    res.status = mprs_pkg::ST_OK;
                end
            end
            mprs_pkg::REQ_POLL: begin
                // The due test is done one bit wider, so a late time never wraps to due.
                if (!sch_active) begin
                    res.status = mprs_pkg::ST_INACTIVE;
                end else if (sch_count == 0 ||
                             !({1'b0, sch_time[0]} + 33'(cfg_ri) < {1'b0, now})) begin
                    res.status = mprs_pkg::ST_NOT_DUE;
                end else begin
                    head = sch_piece[0];
                    drop_entry(0);
                    sch_piece[sch_count] = head;
                    sch_time[sch_count]  = now;
                    sch_count++;
                    res.grant  = head;
                    res.status = mprs_pkg::ST_OK;
                    grants++;
                end
            end
            mprs_pkg::REQ_PIECE: begin
                if (!sch_active) begin
                    res.status = mprs_pkg::ST_INACTIVE;
                end else if (int'(idx) * PIECE_BYTES + int'(len) > int'(cfg_md)) begin
                    res.status = mprs_pkg::ST_TOO_LONG;
                end else begin
                    pos = -1;
                    for (int i = 0; i < sch_count; i++) begin
                        if (pos < 0 && sch_piece[i] == idx) pos = i;
                    end
                    if (pos < 0) begin
                        res.status = mprs_pkg::ST_NOT_NEEDED;
                    end else begin
                        drop_entry(pos);
                        res.status = mprs_pkg::ST_OK;
                        res.all_rx = (sch_count == 0);
                        if (sch_count == 0) lists_emptied++;
                    end
                end
            end
            mprs_pkg::REQ_VERDICT: begin
                if (!sch_active) begin
                    res.status = mprs_pkg::ST_INACTIVE;
                end else if (sch_count != 0 || sch_total == 0) begin
                    res.status = mprs_pkg::ST_NOT_NEEDED;
                end else begin
                    if (ok) begin
                        sch_done   = 1'b1;
                        sch_active = 1'b0;
                    end else begin
                        refill_list();
                        refills++;
                    end
                    res.status = mprs_pkg::ST_OK;
                end
            end
        endcase
        res.remaining = mprs_pkg::CNT_OUT_W'(sch_count);
        res.total     = mprs_pkg::CNT_OUT_W'(sch_total);
        res.finished  = sch_done;
        return res;
    endfunction

    // Offers one item on the input channel and records its expected result once it is
    // taken. Valid is left high after the transfer; the next call either replaces the
    // payload in the same step or lowers valid for an idle gap.
    task automatic send_item(
        input logic [mprs_pkg::REQ_W-1:0]  kind,
        input logic [mprs_pkg::TIME_W-1:0] now,
        input logic [mprs_pkg::IDX_W-1:0]  idx,
        input logic [mprs_pkg::LEN_W-1:0]  len,
        input logic                        ok,
        input bit                          typed,
        input t_sched_result               want
    );
        t_sched_result predicted;
        int idle_pct;
        if (items_sent < 200) begin
            idle_pct      = 7;
            out_stall_pct = 66;
        end else if (items_sent < 400) begin
            idle_pct      = 66;
            out_stall_pct = 7;
        end else begin
            idle_pct      = 0;
            out_stall_pct = 0;
        end
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= kind;
        i_now_secs    <= now;
        i_piece_index <= idx;
        i_piece_len   <= len;
        i_verify_ok   <= ok;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = advance_scheduler(kind, now, idx, len, ok);
        awaited_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Holds the sender back until every outstanding result has been taken.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    // Writes both registers once the block has gone quiet.
    task automatic reconfigure(input logic [mprs_pkg::META_W-1:0] md,
                               input logic [mprs_pkg::INTERVAL_W-1:0] ri);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= mprs_pkg::CFG_METADATA_BYTES;
        i_cfg_data  <= mprs_pkg::CFG_DATA_W'(md);
        @(posedge i_clk);
        i_cfg_index <= mprs_pkg::CFG_REPEAT_INTERVAL;
        i_cfg_data  <= mprs_pkg::CFG_DATA_W'(ri);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_md = md;
        cfg_ri = ri;
        config_writes += 2;
    endtask

    // Draws one random item. Most items follow the normal life of a download: polls with
    // a clock that moves forward, receipts of pieces that are still needed, and a failed
    // verdict once the list runs dry so the list is filled again. The rest is noise.
    task automatic draw_item(
        output logic [mprs_pkg::REQ_W-1:0]  kind,
        output logic [mprs_pkg::TIME_W-1:0] now,
        output logic [mprs_pkg::IDX_W-1:0]  idx,
        output logic [mprs_pkg::LEN_W-1:0]  len,
        output logic                        ok
    );
        int pick;
        int room;
        bit waiting_verdict;
        kind = mprs_pkg::REQ_W'($urandom);
        now  = $urandom;
        idx  = mprs_pkg::IDX_W'($urandom);
        len  = mprs_pkg::LEN_W'($urandom);
        ok   = 1'($urandom);
        pick = $urandom_range(0, 99);
        waiting_verdict = sch_active && sch_count == 0 && sch_total != 0;
        if (waiting_verdict && pick < 70) begin
            kind = mprs_pkg::REQ_VERDICT;
        end else if (pick < 45 && sch_count != 0) begin
            kind = mprs_pkg::REQ_PIECE;
            idx  = sch_piece[$urandom_range(0, sch_count - 1)];
            room = int'(cfg_md) - int'(idx) * PIECE_BYTES;
            if (room >= 0) begin
                len = mprs_pkg::LEN_W'($urandom_range(0, (room > LEN_MAX) ? LEN_MAX : room));
            end
        end else if (pick < 78) begin
            kind = mprs_pkg::REQ_POLL;
            if ($urandom_range(0, 49) != 0) begin
                poll_clock += $urandom_range(0, int'(cfg_ri) / 2 + 2);
                now = poll_clock;
            end
        end else if (pick < 88) begin
            kind = mprs_pkg::REQ_PIECE;
        end else if (pick < 96) begin
            kind = mprs_pkg::REQ_VERDICT;
        end else begin
            kind = mprs_pkg::REQ_START;
        end
        // A passing verdict ends the session for good, so it is saved for the very end.
        if (kind == mprs_pkg::REQ_VERDICT && waiting_verdict) ok = 1'b0;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Result side: random back-pressure, in-order checking and the watchdog.
    always @(posedge i_clk) begin : result_check
        t_sched_result oldest;
        i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no item outstanding: status %0d", o_status);
                    mismatches++;
                end else begin
                    oldest = awaited_results.pop_front();
                    compare_field("status", oldest.status, o_status);
                    compare_field("request_piece", oldest.grant, o_request_piece);
                    compare_field("all_received", oldest.all_rx, o_all_received);
                    compare_field("pieces_remaining", oldest.remaining, o_pieces_remaining);
                    compare_field("pieces_total", oldest.total, o_pieces_total);
                    compare_field("finished", oldest.finished, o_finished);
                    results_checked++;
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int row;
        int left;
        int phase_len;
        int k;
        logic [mprs_pkg::META_W-1:0]     md;
        logic [mprs_pkg::INTERVAL_W-1:0] ri;
        logic [mprs_pkg::REQ_W-1:0]      kind;
        logic [mprs_pkg::TIME_W-1:0]     now;
        logic [mprs_pkg::IDX_W-1:0]      idx;
        logic [mprs_pkg::LEN_W-1:0]      len;
        logic                            ok;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < DIR_ROWS; row++) begin
            if (dir_rows[row].set_cfg) begin
                reconfigure(dir_rows[row].md_bytes, dir_rows[row].interval);
            end
            send_item(dir_rows[row].kind, dir_rows[row].now, dir_rows[row].idx,
                      dir_rows[row].len, dir_rows[row].ok, dir_rows[row].typed,
                      dir_rows[row].want);
        end

        // Only the first start after reset builds the list, so the random part works on
        // that list and moves the size and interval registers between phases. Sizes well
        // above the list keep pieces receivable; small ones turn most receipts away.
        left = RANDOM_ITEMS;
        while (left > 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: md = mprs_pkg::META_W'(META_MAX);
                4, 5:       md = 21'd1048576;
                6:          md = '0;
                7:          md = mprs_pkg::META_W'($urandom_range(0, META_MAX));
                default:    md = mprs_pkg::META_W'($urandom_range(1, 200000));
            endcase
            case ($urandom_range(0, 3))
                0:       ri = '0;
                1:       ri = 8'd255;
                2:       ri = mprs_pkg::REPEAT_RESET;
                default: ri = mprs_pkg::INTERVAL_W'($urandom_range(0, 255));
            endcase
            reconfigure(md, ri);
            phase_len = $urandom_range(30, 80);
            for (k = 0; k < phase_len && left > 0; k++) begin
                draw_item(kind, now, idx, len, ok);
                send_item(kind, now, idx, len, ok, 1'b0, '0);
                left--;
            end
        end

        // Closing session: receive every piece still needed, accept the metadata, then
        // confirm that the finished block turns everything away.
        reconfigure(mprs_pkg::META_W'(META_MAX), '0);
        while (sch_count != 0) begin
            idx = sch_piece[$urandom_range(0, sch_count - 1)];
            send_item(mprs_pkg::REQ_PIECE, $urandom, idx,
                      mprs_pkg::LEN_W'($urandom_range(0, PIECE_BYTES)),
                      1'($urandom), 1'b0, '0);
        end
        send_item(mprs_pkg::REQ_VERDICT, $urandom, mprs_pkg::IDX_W'($urandom),
                  mprs_pkg::LEN_W'($urandom), 1'b1, 1'b0, '0);
        for (k = 0; k < 8; k++) begin
            send_item(mprs_pkg::REQ_W'($urandom), $urandom, mprs_pkg::IDX_W'($urandom),
                      mprs_pkg::LEN_W'($urandom), 1'($urandom), 1'b0, '0);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items, %0d results checked, %0d register writes.",
                 items_sent, results_checked, config_writes);
        $display("Polls granted %0d, lists emptied %0d, refills %0d, finished %0d.",
                 grants, lists_emptied, refills, sch_done);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
